[rtl/core/bitmap_first_free_allocator_assert.svh]
// Assertion macros used by the allocator port checker.
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BMFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/bmfa_pkg.sv]
package bmfa_pkg;

	localparam int BITS   = 4096;
	localparam int CMD_W  = 1;
	localparam int IDX_W  = 12;
	localparam int POOL_W = 13;
	localparam int FREE_W = 13;

	localparam logic [POOL_W-1:0] POOL_RESET = 13'd4096;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              ok;
		logic [IDX_W-1:0]  granted_index;
		logic [FREE_W-1:0] free_units;
	} res_t;

endpackage

[rtl/core/bmfa_map_ram.sv]
module bmfa_map_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/bmfa_engine.sv]
module bmfa_engine #(
	parameter int WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bmfa_pkg::POOL_W-1:0]  pool_size,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  bmfa_pkg::cmd_t               cmd,
	input  logic [bmfa_pkg::IDX_W-1:0]   unit_index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output bmfa_pkg::res_t               res
);

	localparam int BITS      = bmfa_pkg::BITS;
	// WORD_BITS must be a power of two
	localparam int WSH       = $clog2(WORD_BITS);
	localparam int MAP_WORDS = (BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CNT_W     = $clog2(BITS + 1);
	localparam int LIM_W     = (CNT_W > bmfa_pkg::POOL_W) ? CNT_W : bmfa_pkg::POOL_W;
	localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(BITS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FREE,
		ST_RESP
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        chk_q;
	logic [AW-1:0]        lw_q;
	logic [WSH-1:0]       lb_q;
	logic [WSH-1:0]       bit_q;
	logic [CNT_W-1:0]     cnt_q;
	bmfa_pkg::res_t       res_q;
	bmfa_pkg::res_t       out_q;
	logic                 out_valid_q;

	logic                 ram_wr_en;
	logic [AW-1:0]        ram_wr_addr;
	logic [WORD_BITS-1:0] ram_wr_data;
	logic                 ram_rd_en;
	logic [AW-1:0]        ram_rd_addr;
	logic [WORD_BITS-1:0] ram_rd_data;

	logic [LIM_W-1:0]     pool_ext;
	logic [LIM_W-1:0]     lim;
	logic [LIM_W-1:0]     lim_m1;
	logic [LIM_W-1:0]     idx_ext;
	logic                 accept;
	logic [WORD_BITS-1:0] vmask;
	logic [WORD_BITS-1:0] busy_word;
	logic                 found;
	logic [WSH-1:0]       pos;
	logic                 last;
	logic                 slot_free;
	logic [CNT_W-1:0]     cnt_dec;
	logic [CNT_W-1:0]     cnt_inc;

	function automatic logic [WSH-1:0] low_zero(input logic [WORD_BITS-1:0] w);
		logic [WSH-1:0] r;
		int i;
		r = '0;
		for (i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = WSH'(i);
			end
		end
		return r;
	endfunction

	bmfa_map_ram #(
		.DEPTH (MAP_WORDS),
		.AW    (AW),
		.DW    (WORD_BITS)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign pool_ext  = LIM_W'(pool_size);
	assign lim       = (pool_ext > LIM_W'(BITS)) ? LIM_W'(BITS) : pool_ext;
	assign lim_m1    = lim - LIM_W'(1);
	assign idx_ext   = LIM_W'(unit_index);
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = (state_q == ST_IDLE) && in_valid;
	assign last      = (chk_q == lw_q);
	assign slot_free = !out_valid_q || !out_stall;
	assign cnt_dec   = (cnt_q != '0) ? cnt_q - CNT_W'(1) : cnt_q;
	assign cnt_inc   = (cnt_q != CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;

	// units at or above the pool limit count as used
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			vmask[b] = !last || (WSH'(b) <= lb_q);
		end
	end

	assign busy_word = ram_rd_data | ~vmask;
	assign found     = ~&busy_word;
	assign pos       = low_zero(busy_word);

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = chk_q;
		ram_wr_data = '0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
			end
			ST_IDLE: begin
				if (accept) begin
					ram_rd_en = 1'b1;
					if (cmd == bmfa_pkg::CMD_FREE) begin
						ram_rd_addr = AW'(idx_ext >> WSH);
					end
				end
			end
			ST_SCAN: begin
				if (found) begin
					ram_wr_en   = 1'b1;
					ram_wr_data = ram_rd_data | (WORD_BITS'(1) << pos);
				end else if (!last) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = chk_q + AW'(1);
				end
			end
			ST_FREE: begin
				ram_wr_en   = 1'b1;
				ram_wr_data = ram_rd_data & ~(WORD_BITS'(1) << bit_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			chk_q       <= '0;
			lw_q        <= '0;
			lb_q        <= '0;
			bit_q       <= '0;
			cnt_q       <= CNT_MAX;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_RESP)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_q.ok            <= 1'b0;
						res_q.granted_index <= '0;
						res_q.free_units    <= bmfa_pkg::FREE_W'(cnt_q);
						if (cmd == bmfa_pkg::CMD_ALLOC) begin
							chk_q <= '0;
							lw_q  <= AW'(lim_m1 >> WSH);
							lb_q  <= lim_m1[WSH-1:0];
							state_q <= (lim == '0) ? ST_RESP : ST_SCAN;
						end else begin
							chk_q <= AW'(idx_ext >> WSH);
							bit_q <= idx_ext[WSH-1:0];
							state_q <= (idx_ext < lim) ? ST_FREE : ST_RESP;
						end
					end
				end
				ST_SCAN: begin
					if (found) begin
						cnt_q               <= cnt_dec;
						res_q.ok            <= 1'b1;
						res_q.granted_index <= bmfa_pkg::IDX_W'({chk_q, pos});
						res_q.free_units    <= bmfa_pkg::FREE_W'(cnt_dec);
						state_q             <= ST_RESP;
					end else if (last) begin
						state_q <= ST_RESP;
					end else begin
						chk_q <= chk_q + AW'(1);
					end
				end
				ST_FREE: begin
					cnt_q            <= cnt_inc;
					res_q.ok         <= 1'b1;
					res_q.free_units <= bmfa_pkg::FREE_W'(cnt_inc);
					state_q          <= ST_RESP;
				end
				ST_RESP: begin
					if (slot_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;

endmodule

[rtl/core/bitmap_first_free_allocator.sv]
// Allocate reads bitmap words one per cycle, at most BITS/WORD_BITS = 128, then registers
// its result; a free reads and rewrites one word; an out-of-range free or zero pool size skips both.
// One item at a time: the next item is taken in the cycle after its result is registered,
// and a stalled result blocks the output and with it the next item.
// Reset: counter to BITS, pool_size to 4096; a clearing pass zeroes every word of
// the map RAM while in_stall is high.
module bitmap_first_free_allocator #(
	parameter int WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bmfa_pkg::POOL_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bmfa_pkg::CMD_W-1:0]   cmd,
	input  logic [bmfa_pkg::IDX_W-1:0]   unit_index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         ok,
	output logic [bmfa_pkg::IDX_W-1:0]   granted_index,
	output logic [bmfa_pkg::FREE_W-1:0]  free_units
);

	logic [bmfa_pkg::POOL_W-1:0] pool_size_q;
	bmfa_pkg::res_t              res;
	bmfa_pkg::cmd_t              cmd_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= bmfa_pkg::POOL_RESET;
		end else if (cfg_we) begin
			pool_size_q <= cfg_wdata;
		end
	end

	assign cmd_op = bmfa_pkg::cmd_t'(cmd);

	bmfa_engine #(
		.WORD_BITS (WORD_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.pool_size  (pool_size_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd_op),
		.unit_index (unit_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res        (res)
	);

	assign ok            = res.ok;
	assign granted_index = res.granted_index;
	assign free_units    = res.free_units;

endmodule

[rtl/core/bmfa_port_chk.sv]
`include "bitmap_first_free_allocator_assert.svh"

module bmfa_port_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         ok,
	input logic [bmfa_pkg::IDX_W-1:0]   granted_index,
	input logic [bmfa_pkg::FREE_W-1:0]  free_units
);

	`BMFA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`BMFA_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(ok) && $stable(granted_index) && $stable(free_units), "stalled result changed")
	`BMFA_ASSERT_IMP(a_fail_zero, out_valid && !ok, granted_index == '0, "failed item has nonzero index")
	`BMFA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second item taken while busy")

endmodule

bind bitmap_first_free_allocator bmfa_port_chk u_port_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.ok            (ok),
	.granted_index (granted_index),
	.free_units    (free_units)
);

[sim/bitmap_first_free_allocator_tb.sv]
`timescale 1ns / 100ps

module bitmap_first_free_allocator_tb;

	localparam int UNITS = bmfa_pkg::BITS;

	typedef struct packed {
		bmfa_pkg::cmd_t             op;
		logic [bmfa_pkg::IDX_W-1:0] unit;
	} req_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [bmfa_pkg::POOL_W-1:0]   cfg_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	bmfa_pkg::cmd_t                cmd_drv = bmfa_pkg::CMD_ALLOC;
	logic [bmfa_pkg::IDX_W-1:0]    unit_index_drv = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          ok;
	logic [bmfa_pkg::IDX_W-1:0]    granted_index;
	logic [bmfa_pkg::FREE_W-1:0]   free_units;

	bitmap_first_free_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd_drv),
		.unit_index    (unit_index_drv),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.granted_index (granted_index),
		.free_units    (free_units)
	);

	// allocator shadow state
	bit                          used_units [UNITS];
	logic [bmfa_pkg::FREE_W-1:0] free_cnt;
	logic [bmfa_pkg::POOL_W-1:0] pool_sz;

	req_t requests[$];
	bmfa_pkg::res_t grants_due[$];

	bit took_in = 1'b0;
	bit calm = 1'b0;
	int src_gap = 0;
	int snk_hold = 0;
	int errors = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void first_fit(req_t r);
		bmfa_pkg::res_t res;
		int lim;
		int u;
		lim = (pool_sz > UNITS) ? UNITS : int'(pool_sz);
		res = '0;
		if (r.op == bmfa_pkg::CMD_ALLOC) begin
			for (u = 0; u < lim; u++) begin
				if (!used_units[u]) begin
					used_units[u] = 1'b1;
					if (free_cnt > 0)
						free_cnt = free_cnt - 1'b1;
					res.ok = 1'b1;
					res.granted_index = u[bmfa_pkg::IDX_W-1:0];
					break;
				end
			end
		end else if (int'(r.unit) < lim) begin
			used_units[r.unit] = 1'b0;
			if (free_cnt < UNITS)
				free_cnt = free_cnt + 1'b1;
			res.ok = 1'b1;
		end
		res.free_units = free_cnt;
		grants_due.push_back(res);
	endfunction

	task automatic push_req(bmfa_pkg::cmd_t op, int unit);
		req_t r;
		r.op = op;
		r.unit = unit[bmfa_pkg::IDX_W-1:0];
		requests.push_back(r);
	endtask

	task automatic wait_idle();
		while (requests.size() != 0 || in_valid || grants_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_pool(logic [bmfa_pkg::POOL_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		pool_sz = v;
	endtask

	task automatic queue_mix(int n, int lim);
		req_t r;
		int hi;
		hi = (lim + 1 > UNITS - 1) ? UNITS - 1 : lim + 1;
		repeat (n) begin
			r.op = $urandom_range(0, 1) ? bmfa_pkg::CMD_FREE : bmfa_pkg::CMD_ALLOC;
			if (lim > 0 && $urandom_range(0, 9) < 7)
				r.unit = bmfa_pkg::IDX_W'($urandom_range(0, hi));
			else
				r.unit = bmfa_pkg::IDX_W'($urandom());
			requests.push_back(r);
		end
	endtask

	// request driver
	always @(negedge clk) begin : drive
		req_t nxt;
		if (arst_n) begin
			if (!(in_valid && !took_in)) begin
				if (src_gap == 0 && !calm && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 6);
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (requests.size() > 0) begin
					nxt = requests.pop_front();
					in_valid <= 1'b1;
					cmd_drv <= nxt.op;
					unit_index_drv <= nxt.unit;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (snk_hold == 0 && !calm && $urandom_range(0, 7) == 0)
			snk_hold = $urandom_range(1, 6);
		if (snk_hold > 0) begin
			snk_hold--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// accept tracking and result check
	always @(posedge clk) begin : watch
		bmfa_pkg::res_t e;
		took_in = arst_n && in_valid && !in_stall;
		if (took_in)
			first_fit('{op: cmd_drv, unit: unit_index_drv});
		if (arst_n && out_valid && !out_stall) begin
			if (grants_due.size() == 0) begin
				$display("%0t: unexpected result ok=%0d index=%0d free=%0d", $time,
					ok, granted_index, free_units);
				errors++;
			end else begin
				e = grants_due.pop_front();
				if (ok !== e.ok) begin
					$display("%0t: ok expected %0d, got %0d", $time, e.ok, ok);
					errors++;
				end
				if (granted_index !== e.granted_index) begin
					$display("%0t: granted_index expected %0d, got %0d", $time,
						e.granted_index, granted_index);
					errors++;
				end
				if (free_units !== e.free_units) begin
					$display("%0t: free_units expected %0d, got %0d", $time,
						e.free_units, free_units);
					errors++;
				end
			end
		end
	end

	initial begin
		int lim;
		logic [bmfa_pkg::POOL_W-1:0] p;
		foreach (used_units[i])
			used_units[i] = 1'b0;
		free_cnt = bmfa_pkg::FREE_W'(UNITS);
		pool_sz = bmfa_pkg::POOL_RESET;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// counter pinned at the top, double frees
		push_req(bmfa_pkg::CMD_FREE, 5);
		push_req(bmfa_pkg::CMD_ALLOC, 4095);
		push_req(bmfa_pkg::CMD_FREE, 7);
		push_req(bmfa_pkg::CMD_FREE, 0);
		push_req(bmfa_pkg::CMD_FREE, 4095);
		// fill a small pool, then run dry
		set_pool(13'd40);
		repeat (42)
			push_req(bmfa_pkg::CMD_ALLOC, $urandom_range(0, UNITS - 1));
		push_req(bmfa_pkg::CMD_FREE, 4095);
		push_req(bmfa_pkg::CMD_FREE, 4095);
		push_req(bmfa_pkg::CMD_ALLOC, 0);
		push_req(bmfa_pkg::CMD_FREE, 0);
		push_req(bmfa_pkg::CMD_ALLOC, 0);

		set_pool(13'h1FFF);
		push_req(bmfa_pkg::CMD_ALLOC, 0);
		push_req(bmfa_pkg::CMD_FREE, 2048);
		push_req(bmfa_pkg::CMD_ALLOC, 0);

		set_pool(13'd0);
		push_req(bmfa_pkg::CMD_ALLOC, 0);
		push_req(bmfa_pkg::CMD_FREE, 0);
		push_req(bmfa_pkg::CMD_FREE, 4095);

		set_pool(13'd1);
		push_req(bmfa_pkg::CMD_ALLOC, 0);
		push_req(bmfa_pkg::CMD_FREE, 0);
		push_req(bmfa_pkg::CMD_ALLOC, 0);
		push_req(bmfa_pkg::CMD_FREE, 1);
		push_req(bmfa_pkg::CMD_ALLOC, 0);

		for (int k = 0; k < 10; k++) begin
			case (k)
				0: p = 13'd4096;
				1: p = 13'h1FFF;
				2: p = 13'd0;
				3: p = 13'd1;
				4: p = 13'd2;
				5: p = 13'd33;
				6: p = bmfa_pkg::POOL_W'($urandom_range(3, 64));
				7: p = bmfa_pkg::POOL_W'($urandom_range(65, 4095));
				8: p = bmfa_pkg::POOL_W'($urandom_range(4097, 8190));
				default: p = 13'd4096;
			endcase
			set_pool(p);
			lim = (p > UNITS) ? UNITS : int'(p);
			if (k == 9)
				calm = 1'b1;
			queue_mix(169, lim);
		end

		wait_idle();
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bmfa_pkg.sv
rtl/core/bmfa_map_ram.sv
rtl/core/bmfa_engine.sv
rtl/core/bitmap_first_free_allocator.sv
rtl/core/bmfa_port_chk.sv
sim/bitmap_first_free_allocator_tb.sv
